// ===== rtl/core/geared_output_shaft_angle_defines.svh =====
// assertion helpers shared by the rtl
`ifndef GEARED_OUTPUT_SHAFT_ANGLE_DEFINES_SVH
`define GEARED_OUTPUT_SHAFT_ANGLE_DEFINES_SVH

// same-cycle implication on clk, off during reset
`define GOSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, off during reset
`define GOSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gosa_pkg.sv =====
package gosa_pkg;

    localparam int FRAC_BITS = 8;

    localparam int ANGLE_W  = 17;
    localparam int OUT_W    = 18;
    localparam int CNT_W    = 18;
    localparam int GEAR_W   = 16;
    localparam int ACC_W    = 35;
    localparam int PROD_W   = ACC_W + 1;
    localparam int MAG_W    = ACC_W - 1;
    localparam int LIMIT_W  = ANGLE_W + GEAR_W;
    localparam int WRAP_W   = ANGLE_W + 2;
    localparam int STEP_W   = $clog2(MAG_W);
    localparam int IN_TDATA_W  = ((ANGLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(360 * (2 ** FRAC_BITS));
    localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(180 * (2 ** FRAC_BITS));
    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(MAG_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_WRAP,
        ST_DONE
    } gosa_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } gosa_seq_t;

endpackage

// ===== rtl/core/gosa_div.sv =====
module gosa_div
    import gosa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  gosa_seq_t         seq,
    input  logic [MAG_W-1:0]  dividend,
    input  logic [GEAR_W-1:0] divisor,
    output logic              q_bit
);

    logic [MAG_W-1:0]  dvd_reg;
    logic [MAG_W-1:0]  dvd_next;
    logic [GEAR_W-1:0] rem_reg;
    logic [GEAR_W-1:0] rem_next;
    logic [GEAR_W:0]   rem_shift;
    logic [GEAR_W:0]   rem_diff;

    // one quotient bit per cycle while seq.step is high, msb first
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[MAG_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor};
        q_bit     = (rem_shift >= {1'b0, divisor});
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (seq.load)
        begin
            dvd_next = dividend;
            rem_next = '0;
        end
        else if (seq.step)
        begin
            dvd_next = {dvd_reg[MAG_W-2:0], 1'b0};
            rem_next = q_bit ? rem_diff[GEAR_W-1:0] : rem_shift[GEAR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// ===== rtl/core/gosa_mod.sv =====
module gosa_mod
    import gosa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  gosa_seq_t          seq,
    input  logic               q_bit,
    output logic [ANGLE_W-1:0] rem
);

    logic [ANGLE_W-1:0] r_reg;
    logic [ANGLE_W-1:0] r_next;
    logic [ANGLE_W:0]   r_shift;
    logic [ANGLE_W:0]   r_diff;

    // running quotient mod one full turn, one quotient bit per cycle while seq.step is high
    always_comb
    begin
        r_shift = {r_reg, q_bit};
        r_diff  = r_shift - {1'b0, FULL_TURN};
        r_next  = r_reg;
        if (seq.load)
        begin
            r_next = '0;
        end
        else if (seq.step)
        begin
            r_next = (r_shift >= {1'b0, FULL_TURN}) ? r_diff[ANGLE_W-1:0]
                                                     : r_shift[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= '0;
        end
        else
        begin
            r_reg <= r_next;
        end
    end

    assign rem = r_reg;

endmodule

// ===== rtl/core/geared_output_shaft_angle.sv =====
// first sample after reset: accept leads straight to ST_DONE and the output register;
// later samples pass ST_MUL, ST_CHECK, the 34-step serial divider and ST_WRAP first
// a sample is taken only in ST_IDLE, once the last result is in the output register
// the result waits in an output register, so a stalled m_axis side holds back the next
// result in ST_DONE, and the accept after it, but not the next accept
// reset: asynchronous, clears turn count, last angle and first-sample flag, gear ratio to 1
`include "geared_output_shaft_angle_defines.svh"

module geared_output_shaft_angle
    import gosa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [16:0] motor_angle
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [17:0] shaft_angle
    input  logic                   cfg_wr_en,
    input  logic [GEAR_W-1:0]      cfg_wr_data
);

    gosa_state_t state_reg;
    gosa_state_t state_next;
    gosa_seq_t   seq;

    logic [GEAR_W-1:0]  gear_reg;
    logic [GEAR_W-1:0]  gear_eff;
    logic [ANGLE_W-1:0] prev_reg;
    logic [ANGLE_W-1:0] cur_reg;
    logic               seen_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [ACC_W-1:0]   acc_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               neg_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [OUT_W-1:0]   result_reg;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    logic               accept;
    logic               out_load;
    logic [ANGLE_W-1:0] cur_in;
    logic signed [ANGLE_W:0] delta;
    logic [PROD_W-1:0]  prod;
    logic [ACC_W-1:0]   acc_neg;
    logic [MAG_W-1:0]   mag;
    logic               q_bit;
    logic [ANGLE_W-1:0] mod_rem;
    logic signed [WRAP_W-1:0] r_s;
    logic signed [WRAP_W-1:0] r_w1;
    logic signed [WRAP_W-1:0] r_w2;

    assign cur_in   = s_axis_tdata[ANGLE_W-1:0];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);
    assign gear_eff = (gear_reg == '0) ? GEAR_W'(1) : gear_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = seen_reg ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:   state_next = ST_CHECK;
            ST_CHECK: state_next = ST_DIV;
            ST_DIV:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        seq.load      = 1'b0;
        seq.step      = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_CHECK: seq.load      = 1'b1;
            ST_DIV:   seq.step      = 1'b1;
            default:  ;
        endcase
    end

    // turn counting on the new sample
    always_comb
    begin
        delta    = $signed({1'b0, cur_in}) - $signed({1'b0, prev_reg});
        cnt_next = cnt_reg;
        if (delta > $signed({1'b0, HALF_TURN}))
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else if (delta < -$signed({1'b0, HALF_TURN}))
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    assign prod    = PROD_W'($signed(cnt_reg)) * PROD_W'(FULL_TURN) + PROD_W'(cur_reg);
    assign acc_neg = -acc_reg;
    assign mag     = acc_reg[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_reg[MAG_W-1:0];

    // wrap into (-180, 180]
    always_comb
    begin
        r_s  = neg_reg ? -$signed(WRAP_W'(mod_rem)) : $signed(WRAP_W'(mod_rem));
        r_w1 = r_s;
        if (r_s > $signed(WRAP_W'(HALF_TURN)))
        begin
            r_w1 = r_s - $signed(WRAP_W'(FULL_TURN));
        end
        r_w2 = r_w1;
        if (r_w1 <= -$signed(WRAP_W'(HALF_TURN)))
        begin
            r_w2 = r_w1 + $signed(WRAP_W'(FULL_TURN));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gear_reg      <= GEAR_W'(1);
            prev_reg      <= '0;
            cur_reg       <= '0;
            seen_reg      <= 1'b0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            limit_reg     <= '0;
            neg_reg       <= 1'b0;
            step_reg      <= '0;
            result_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                gear_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                cur_reg  <= cur_in;
                prev_reg <= cur_in;
                if (!seen_reg)
                begin
                    seen_reg   <= 1'b1;
                    result_reg <= OUT_W'(cur_in);
                end
                else
                begin
                    cnt_reg <= cnt_next;
                end
            end
            if (state_reg == ST_MUL)
            begin
                acc_reg   <= prod[ACC_W-1:0];
                limit_reg <= LIMIT_W'(FULL_TURN) * LIMIT_W'(gear_eff);
            end
            if (state_reg == ST_CHECK)
            begin
                neg_reg  <= acc_reg[ACC_W-1];
                step_reg <= '0;
                if (mag >= MAG_W'(limit_reg))
                begin
                    cnt_reg <= '0;
                end
            end
            if (state_reg == ST_DIV)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (state_reg == ST_WRAP)
            begin
                result_reg <= r_w2[OUT_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= result_reg;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    gosa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .seq      (seq),
        .dividend (mag),
        .divisor  (gear_eff),
        .q_bit    (q_bit)
    );

    gosa_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .seq   (seq),
        .q_bit (q_bit),
        .rem   (mod_rem)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

    `GOSA_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE, "accept did not start work")
    `GOSA_ASSERT_NEXT(a_div_runs_full, (state_reg == ST_DIV) && (step_reg != STEP_LAST), state_reg == ST_DIV, "divider cut short")
    `GOSA_ASSERT_NOW(a_mod_bounded, state_reg == ST_WRAP, mod_rem < FULL_TURN, "remainder not reduced")
    `GOSA_ASSERT_NEXT(a_wrap_range, state_reg == ST_WRAP, ($signed(result_reg) > -$signed(OUT_W'(HALF_TURN))) && ($signed(result_reg) <= $signed(OUT_W'(HALF_TURN))), "wrapped angle out of range")

endmodule
